// ===== design/apfp_pkg.sv =====
package apfp_pkg;

    localparam logic [7:0] HDR_POS  = 8'h55;
    localparam logic [7:0] HDR_CMD  = 8'h66;
    localparam logic [7:0] MINUS_CH = 8'h2D;
    localparam logic [7:0] TRAILER  = 8'hFF;
    localparam logic [7:0] ZERO_CH  = 8'h30;
    localparam logic [7:0] MODE_MAX = 8'd5;

    localparam int unsigned STORE_DEPTH = 8;
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [3:0] SIGN_CNT    = 4'd4;
    localparam logic [3:0] POS_LEN     = 4'd7;
    localparam logic [3:0] POS_LEN_NEG = 4'd8;

    localparam logic [IDX_W-1:0] SIGN_IDX = 3'd3;

    // three digits weighted 100, 10, 1 each carry the ASCII zero offset
    localparam logic [15:0] DIGIT_BIAS = 16'(ZERO_CH) * 16'd111;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_POS_DATA = 3'd1,
        PH_POS_TAIL = 3'd2,
        PH_CMD_DATA = 3'd3,
        PH_CMD_TAIL = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_POS    = 2'd0,
        ST_MODE   = 2'd1,
        ST_CHARGE = 2'd2,
        ST_BAD    = 2'd3
    } t_status;

    typedef logic [STORE_DEPTH-1:0][7:0] t_store;

    typedef struct packed {
        logic    vld;
        t_status status;
    } t_event;

    typedef struct packed {
        t_status     status;
        logic [15:0] distance;
        logic [15:0] angle_tenths;
        logic [2:0]  mode;
        logic [7:0]  charge_value;
    } t_result;

endpackage

// ===== design/apfp_if.sv =====
interface apfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface apfp_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic        [15:0] distance;
    logic signed [15:0] angle_tenths;
    logic        [2:0]  mode;
    logic        [7:0]  charge_value;

    modport source (output valid, output status, output distance, output angle_tenths,
                    output mode, output charge_value, input ready);
    modport sink   (input valid, input status, input distance, input angle_tenths,
                    input mode, input charge_value, output ready);
endinterface

// ===== design/apfp_frame_fsm.sv =====
module apfp_frame_fsm
    import apfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_event     o_evt,
    output t_store     o_store,
    output logic       o_neg
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_count, n_count;
    logic       r_neg, n_neg;
    t_store     r_store;
    logic [3:0] w_count_inc;

    assign w_count_inc = r_count + 4'd1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_neg   = r_neg;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == HDR_POS) begin
                    n_phase = PH_POS_DATA;
                    n_count = '0;
                    n_neg   = 1'b0;
                end else if (i_byte == HDR_CMD) begin
                    n_phase = PH_CMD_DATA;
                    n_count = '0;
                end
            end
            PH_POS_DATA: begin
                n_count = w_count_inc;
                if (w_count_inc == SIGN_CNT) begin
                    n_neg = (i_byte == MINUS_CH);
                end
                if (w_count_inc >= SIGN_CNT &&
                    w_count_inc >= (n_neg ? POS_LEN_NEG : POS_LEN)) begin
                    n_phase = PH_POS_TAIL;
                end
            end
            PH_CMD_DATA: begin
                n_count = 4'd1;
                n_phase = PH_CMD_TAIL;
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
    end

    always_comb begin
        o_evt.vld    = 1'b0;
        o_evt.status = ST_BAD;
        unique case (r_phase)
            PH_POS_TAIL: begin
                o_evt.vld    = 1'b1;
                o_evt.status = (i_byte == TRAILER) ? ST_POS : ST_BAD;
            end
            PH_CMD_TAIL: begin
                o_evt.vld = 1'b1;
                if (i_byte != TRAILER) begin
                    o_evt.status = ST_BAD;
                end else if (r_store[0] <= MODE_MAX) begin
                    o_evt.status = ST_MODE;
                end else begin
                    o_evt.status = ST_CHARGE;
                end
            end
            default: begin
                o_evt.vld    = 1'b0;
                o_evt.status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_neg   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && r_phase == PH_POS_DATA) begin
            r_store[r_count[IDX_W-1:0]] <= i_byte;
        end else if (i_fire && r_phase == PH_CMD_DATA) begin
            r_store[0] <= i_byte;
        end
    end

    assign o_store = r_store;
    assign o_neg   = r_neg;

endmodule

// ===== design/apfp_decode.sv =====
module apfp_decode
    import apfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_event  i_evt,
    input  t_store  i_store,
    input  logic    i_neg,
    output t_result o_res
);

    logic [15:0] r_dist, n_dist;
    logic [15:0] r_angle, n_angle;
    logic [2:0]  r_mode, n_mode;
    logic [7:0]  r_charge, n_charge;

    logic [15:0] w_p0, w_p1, w_p2;
    logic [15:0] w_a1, w_a2, w_a3;
    logic [15:0] w_dist, w_angle_mag;

    assign w_p0 = {8'h00, i_store[0]};
    assign w_p1 = {8'h00, i_store[1]};
    assign w_p2 = {8'h00, i_store[2]};
    assign w_a1 = {8'h00, i_neg ? i_store[4] : i_store[3]};
    assign w_a2 = {8'h00, i_neg ? i_store[5] : i_store[4]};
    assign w_a3 = {8'h00, i_neg ? i_store[7] : i_store[6]};

    assign w_dist      = w_p0 * 16'd100 + w_p1 * 16'd10 + w_p2 - DIGIT_BIAS;
    assign w_angle_mag = w_a1 * 16'd100 + w_a2 * 16'd10 + w_a3 - DIGIT_BIAS;

    always_comb begin
        n_dist   = r_dist;
        n_angle  = r_angle;
        n_mode   = r_mode;
        n_charge = r_charge;
        if (i_evt.vld) begin
            unique case (i_evt.status)
                ST_POS: begin
                    n_dist  = w_dist;
                    n_angle = i_neg ? (~w_angle_mag + 16'd1) : w_angle_mag;
                end
                ST_MODE:   n_mode   = i_store[0][2:0];
                ST_CHARGE: n_charge = i_store[0];
                ST_BAD: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist   <= '0;
            r_angle  <= '0;
            r_mode   <= '0;
            r_charge <= '0;
        end else if (i_fire && i_evt.vld) begin
            r_dist   <= n_dist;
            r_angle  <= n_angle;
            r_mode   <= n_mode;
            r_charge <= n_charge;
        end
    end

    assign o_res.status       = i_evt.status;
    assign o_res.distance     = n_dist;
    assign o_res.angle_tenths = n_angle;
    assign o_res.mode         = n_mode;
    assign o_res.charge_value = n_charge;

endmodule

// ===== design/ascii_position_frame_parser_core.sv =====
// Byte deframer for position and command frames.
// i_rx (sink): one received byte per transfer. o_res (source): one result per
// trailer byte, carrying a status code and the held distance, angle, mode and
// charge value after that frame's update; a bad trailer reports status 3 with
// the held values unchanged. Bytes outside a trailer position give no result.
// Datapath: an input register holds the transferred byte, one pass of
// frame-state and constant-multiply logic follows, and an output register
// holds the result. A result is valid once its trailer byte has gone from the
// input register into the output register. One byte is taken in every cycle,
// also while a result waits in the output register, as long as the byte held
// in the input register does not itself produce a result.
// When o_res.ready stays low with a result waiting, the next result-producing
// byte holds in the input register and i_rx.ready drops until the waiting
// result is transferred.
// Synchronous active-low reset returns the parser to idle, clears the held
// values and empties both registers.
module ascii_position_frame_parser_core
    import apfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    apfp_in_if.sink     i_rx,
    apfp_out_if.source  o_res
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;

    logic       w_fire;
    t_event     w_evt;
    t_store     w_store;
    logic       w_neg;
    t_result    w_res;

    assign w_fire     = r_in_vld && (!w_evt.vld || !r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || w_fire;

    apfp_frame_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_evt   (w_evt),
        .o_store (w_store),
        .o_neg   (w_neg)
    );

    apfp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_evt   (w_evt),
        .i_store (w_store),
        .i_neg   (w_neg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire && w_evt.vld) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_fire && w_evt.vld) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.status       = r_out.status;
    assign o_res.distance     = r_out.distance;
    assign o_res.angle_tenths = r_out.angle_tenths;
    assign o_res.mode         = r_out.mode;
    assign o_res.charge_value = r_out.charge_value;

endmodule

// ===== design/apfp_checker.sv =====
module apfp_checker
    import apfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [2:0]  i_mode,
    input logic [7:0]  i_charge
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_mode <= MODE_MAX[2:0])
        else $error("held mode out of range");

    a_charge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_CHARGE |-> i_charge > MODE_MAX)
        else $error("charge result below command threshold");

endmodule

bind ascii_position_frame_parser_core apfp_checker u_apfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_mode      (o_res.mode),
    .i_charge    (o_res.charge_value)
);

// ===== sim/ascii_position_frame_parser_core_tb.sv =====
`timescale 1ns / 100ps

module ascii_position_frame_parser_core_tb;
    import apfp_pkg::*;

    localparam int LIVE_BYTES_GOAL = 1550;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_AT = 800;
    localparam int TAIL_CYCLES = 8;
    localparam int DIR_N = 26;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    exp;
    } t_dir_row;

    localparam t_result NO_RES = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    apfp_in_if  rx_if ();
    apfp_out_if res_if ();

    ascii_position_frame_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    t_phase      frame_phase = PH_IDLE;
    logic [3:0]  data_count = '0;
    logic        neg_angle = 1'b0;
    logic [7:0]  frame_bytes [STORE_DEPTH];
    logic [15:0] hold_dist = '0;
    logic [15:0] hold_angle = '0;
    logic [2:0]  hold_mode = '0;
    logic [7:0]  hold_charge = '0;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      live_bytes = 0;
    bit      steady = 1'b0;
    bit      long_hold_req = 1'b0;

    t_dir_row dir_tab [DIR_N] = '{
        {8'h00, 1'b0, NO_RES},
        {HDR_CMD, 1'b0, NO_RES},
        {8'h05, 1'b0, NO_RES},
        {TRAILER, 1'b1, ST_MODE, 16'd0, 16'd0, 3'd5, 8'd0},
        {HDR_CMD, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {TRAILER, 1'b1, ST_CHARGE, 16'd0, 16'd0, 3'd5, 8'd255},
        {HDR_POS, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {MINUS_CH, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {8'hFF, 1'b0, NO_RES},
        {TRAILER, 1'b1, ST_POS, 16'd22977, 16'hA63F, 3'd5, 8'd255},
        {HDR_POS, 1'b0, NO_RES},
        {8'h00, 1'b0, NO_RES},
        {HDR_POS, 1'b0, NO_RES},
        {HDR_CMD, 1'b0, NO_RES},
        {8'h00, 1'b0, NO_RES},
        {8'h00, 1'b0, NO_RES},
        {8'h00, 1'b0, NO_RES},
        {8'h00, 1'b0, NO_RES},
        {HDR_POS, 1'b1, ST_BAD, 16'd22977, 16'hA63F, 3'd5, 8'd255}
    };

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        int      digit [STORE_DEPTH];
        int      dist_sum;
        int      tenths;
        t_status st;
        r = NO_RES;
        deframe_byte = 1'b0;
        case (frame_phase)
            PH_IDLE: begin
                if (b == HDR_POS) begin
                    frame_phase = PH_POS_DATA;
                    data_count = '0;
                    neg_angle = 1'b0;
                end else if (b == HDR_CMD) begin
                    frame_phase = PH_CMD_DATA;
                    data_count = '0;
                end
            end
            PH_POS_DATA: begin
                frame_bytes[data_count[2:0]] = b;
                data_count = data_count + 4'd1;
                if (data_count == SIGN_CNT)
                    neg_angle = (frame_bytes[SIGN_IDX] == MINUS_CH);
                if (data_count >= (neg_angle ? POS_LEN_NEG : POS_LEN))
                    frame_phase = PH_POS_TAIL;
            end
            PH_POS_TAIL: begin
                frame_phase = PH_IDLE;
                data_count = '0;
                st = ST_BAD;
                if (b == TRAILER) begin
                    for (int i = 0; i < STORE_DEPTH; i++)
                        digit[i] = int'(frame_bytes[i]) - int'(ZERO_CH);
                    dist_sum = 100 * digit[0] + 10 * digit[1] + digit[2];
                    if (neg_angle)
                        tenths = -(10 * (10 * digit[4] + digit[5]) + digit[7]);
                    else
                        tenths = 10 * (10 * digit[3] + digit[4]) + digit[6];
                    hold_dist = 16'(dist_sum);
                    hold_angle = 16'(tenths);
                    st = ST_POS;
                end
                r = '{st, hold_dist, hold_angle, hold_mode, hold_charge};
                deframe_byte = 1'b1;
            end
            PH_CMD_DATA: begin
                frame_bytes[0] = b;
                data_count = 4'd1;
                frame_phase = PH_CMD_TAIL;
            end
            PH_CMD_TAIL: begin
                frame_phase = PH_IDLE;
                data_count = '0;
                st = ST_BAD;
                if (b == TRAILER) begin
                    if (frame_bytes[0] <= MODE_MAX) begin
                        hold_mode = frame_bytes[0][2:0];
                        st = ST_MODE;
                    end else begin
                        hold_charge = frame_bytes[0];
                        st = ST_CHARGE;
                    end
                end
                r = '{st, hold_dist, hold_angle, hold_mode, hold_charge};
                deframe_byte = 1'b1;
            end
            default: begin
                frame_phase = PH_IDLE;
                data_count = '0;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        mismatch_count++;
    endtask

    task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
                           input t_result typed_res = NO_RES);
        int      gap;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        if (frame_phase != PH_IDLE || b == HDR_POS || b == HDR_CMD)
            live_bytes++;
        if (deframe_byte(b, r))
            pending_results.push_back(typed ? typed_res : r);
    endtask

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 99) < 80)
            return ZERO_CH + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] trailer_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 254));
        return TRAILER;
    endfunction

    task automatic send_position_frame();
        bit         neg;
        logic [7:0] b;
        neg = 1'($urandom_range(0, 1));
        send_rx(HDR_POS);
        for (int i = 0; i < (neg ? 8 : 7); i++) begin
            b = data_byte();
            if (i == 3)
                b = neg ? MINUS_CH : ((b == MINUS_CH) ? ZERO_CH : b);
            send_rx(b);
        end
        send_rx(trailer_byte());
    endtask

    task automatic send_command_frame();
        int         r;
        logic [7:0] cmd;
        r = $urandom_range(0, 9);
        if (r < 4)
            cmd = 8'($urandom_range(0, 5));
        else if (r < 8)
            cmd = 8'($urandom_range(6, 255));
        else
            cmd = 8'($urandom_range(0, 255));
        send_rx(HDR_CMD);
        send_rx(cmd);
        send_rx(trailer_byte());
    endtask

    initial begin
        int  pick;
        bit  drained;
        drained = 1'b0;
        i_rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++)
            send_rx(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].exp);

        long_hold_req = 1'b1;
        while (live_bytes < LIVE_BYTES_GOAL) begin
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            if (!drained && live_bytes >= DRAIN_AT) begin
                // hold the sender until every pending result is out
                rx_if.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_position_frame();
            end else if (pick < 80) begin
                send_command_frame();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
            end else begin
                send_rx($urandom_range(0, 1) ? HDR_POS : HDR_CMD);
                repeat ($urandom_range(0, 5)) send_rx(data_byte());
            end
        end

        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                res_if.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending, status", -1, int'(res_if.status));
            end else begin
                want = pending_results.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch("status", int'(want.status), int'(res_if.status));
                if (res_if.distance !== want.distance)
                    report_mismatch("distance", int'(want.distance), int'(res_if.distance));
                if (res_if.angle_tenths !== want.angle_tenths)
                    report_mismatch("angle_tenths", int'($signed(want.angle_tenths)),
                                    int'($signed(res_if.angle_tenths)));
                if (res_if.mode !== want.mode)
                    report_mismatch("mode", int'(want.mode), int'(res_if.mode));
                if (res_if.charge_value !== want.charge_value)
                    report_mismatch("charge_value", int'(want.charge_value),
                                    int'(res_if.charge_value));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== ascii_position_frame_parser_core.f =====
design/apfp_pkg.sv
design/apfp_if.sv
design/apfp_frame_fsm.sv
design/apfp_decode.sv
design/ascii_position_frame_parser_core.sv
design/apfp_checker.sv
sim/ascii_position_frame_parser_core_tb.sv
